// File: design/http_chunked_body_decoder_unit_defines.svh
// assertion macros shared by the chunked body decoder
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HCBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define HCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/hcbd_pkg.sv
// shared types, codes and helpers for the chunked body decoder
package hcbd_pkg;

  localparam int SIZE_BITS = 32;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [1:0] CAUSE_NO_DIGITS = 2'd0;
  localparam logic [1:0] CAUSE_BAD_CHAR  = 2'd1;
  localparam logic [1:0] CAUSE_OVERFLOW  = 2'd2;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic [1:0] kind;
    logic [1:0] cause;
  } step_res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h41 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// File: design/hcbd_step.sv
// chunk framing state machine: one byte per step
module hcbd_step (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic [7:0]            step_byte,
  output hcbd_pkg::step_res_t   step_res
);

  typedef enum logic [2:0] {
    PH_SIZE, PH_EXT, PH_LF, PH_DATA, PH_SKIP, PH_DONE, PH_ERR
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [hcbd_pkg::SIZE_BITS-1:0] acc_r, acc_nxt;
  logic [hcbd_pkg::SIZE_BITS-1:0] rem_r, rem_nxt;
  logic                           seen_r, seen_nxt;
  logic [1:0]                     skip_r, skip_nxt;
  logic [1:0]                     cause_r, cause_nxt;
  hcbd_pkg::hex_t                 hx;

  always_comb begin
    hx        = hcbd_pkg::hex_decode(step_byte);
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    seen_nxt  = seen_r;
    skip_nxt  = skip_r;
    cause_nxt = cause_r;
    step_res  = '0;
    unique case (phase_r)
      PH_SIZE: begin
        if (hx.ok) begin
          if (acc_r[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
            phase_nxt      = PH_ERR;
            cause_nxt      = hcbd_pkg::CAUSE_OVERFLOW;
            step_res.valid = 1'b1;
            step_res.kind  = hcbd_pkg::KIND_ERR;
            step_res.cause = hcbd_pkg::CAUSE_OVERFLOW;
          end else begin
            acc_nxt  = {acc_r[hcbd_pkg::SIZE_BITS-5:0], hx.val};
            seen_nxt = 1'b1;
          end
        end else if (!seen_r) begin
          phase_nxt      = PH_ERR;
          cause_nxt      = hcbd_pkg::CAUSE_NO_DIGITS;
          step_res.valid = 1'b1;
          step_res.kind  = hcbd_pkg::KIND_ERR;
          step_res.cause = hcbd_pkg::CAUSE_NO_DIGITS;
        end else if (step_byte == hcbd_pkg::CH_CR) begin
          phase_nxt = PH_LF;
        end else if (step_byte == hcbd_pkg::CH_SEMI || step_byte == hcbd_pkg::CH_SP ||
                     step_byte == hcbd_pkg::CH_TAB) begin
          phase_nxt = PH_EXT;
        end else begin
          phase_nxt      = PH_ERR;
          cause_nxt      = hcbd_pkg::CAUSE_BAD_CHAR;
          step_res.valid = 1'b1;
          step_res.kind  = hcbd_pkg::KIND_ERR;
          step_res.cause = hcbd_pkg::CAUSE_BAD_CHAR;
        end
      end
      PH_EXT: begin
        if (step_byte == hcbd_pkg::CH_CR) begin
          phase_nxt = PH_LF;
        end
      end
      PH_LF: begin
        if (acc_r == '0) begin
          phase_nxt      = PH_DONE;
          step_res.valid = 1'b1;
          step_res.kind  = hcbd_pkg::KIND_END;
        end else begin
          rem_nxt   = acc_r;
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        rem_nxt = rem_r - hcbd_pkg::SIZE_BITS'(1);
        // last payload byte of this chunk: skip the trailing crlf
        if (rem_r == hcbd_pkg::SIZE_BITS'(1)) begin
          phase_nxt = PH_SKIP;
          skip_nxt  = 2'd2;
        end
        step_res.valid = 1'b1;
        step_res.data  = step_byte;
        step_res.kind  = hcbd_pkg::KIND_DATA;
      end
      PH_SKIP: begin
        skip_nxt = skip_r - 2'd1;
        if (skip_r == 2'd1) begin
          phase_nxt = PH_SIZE;
          acc_nxt   = '0;
          seen_nxt  = 1'b0;
        end
      end
      PH_DONE: begin
        step_res.valid = 1'b1;
        step_res.kind  = hcbd_pkg::KIND_END;
      end
      PH_ERR: begin
        step_res.valid = 1'b1;
        step_res.kind  = hcbd_pkg::KIND_ERR;
        step_res.cause = cause_r;
      end
      default: begin
        phase_nxt = PH_ERR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIZE;
      acc_r   <= '0;
      rem_r   <= '0;
      seen_r  <= 1'b0;
      skip_r  <= 2'd0;
      cause_r <= 2'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      seen_r  <= seen_nxt;
      skip_r  <= skip_nxt;
      cause_r <= cause_nxt;
    end
  end

endmodule

// File: design/http_chunked_body_decoder_unit.sv
// top level of the http chunked body decoder
//
//   channel | direction | ports                                    | moves
//   in      | sink      | in_valid, in_ready, in_body_byte         | one raw body byte per item
//   out     | source    | out_valid, out_ready, out_byte, out_kind, | one decoded item (payload,
//           |           | out_error_cause                          | end of body or error)
//
// one byte per cycle sustained while the output is not stalled; a byte is taken into the input
// register when accepted, then its framing step writes the result register once that is free or being emptied
// a byte that yields nothing (size digits, extension, crlf) leaves no output item
// synchronous active-low reset returns the parser to the size digits phase
// a stalled output holds the input register; in_ready stays high while that register is empty
// or can move forward in the same cycle
`include "http_chunked_body_decoder_unit_defines.svh"

module http_chunked_body_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_body_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic [1:0] out_error_cause
);

  // input register stage
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;

  // result register stage
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic [1:0] out_kind_r;
  logic [1:0] out_cause_r;

  logic                s1_adv;
  logic                in_fire;
  hcbd_pkg::step_res_t res;

  // the held byte moves on when the result slot is free or being emptied
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // framing state only advances when the byte actually leaves stage one
  hcbd_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_adv),
    .step_byte (s1_byte_r),
    .step_res  (res)
  );

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    // a silent byte leaves the slot empty once the old item is taken
    if (s1_adv) begin
      out_valid_nxt = res.valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_body_byte;
    end
    if (s1_adv) begin
      out_byte_r  <= res.data;
      out_kind_r  <= res.kind;
      out_cause_r <= res.cause;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_kind        = out_kind_r;
  assign out_error_cause = out_cause_r;

  // ready only drops while a byte is parked in stage one
  `HCBD_ASSERT_NOW(a_ready_low_holds, clk, rst_n, !in_ready, s1_valid_r,
                   "in_ready low with empty stage")
  // a stalled result with a parked byte keeps that byte
  `HCBD_ASSERT_NEXT(a_stall_keeps_s1, clk, rst_n, s1_valid_r && out_valid_r && !out_ready,
                    s1_valid_r && $stable(s1_byte_r), "stage one lost byte under stall")
  // non-payload results carry a zero byte, payload results a zero cause
  `HCBD_ASSERT_NOW(a_out_fields_clean, clk, rst_n, out_valid,
                   (out_kind == hcbd_pkg::KIND_DATA) ?
                   (out_error_cause == hcbd_pkg::CAUSE_NO_DIGITS) : (out_byte == 8'd0),
                   "result fields inconsistent")

endmodule
